/* sv/assert_macros.svh */
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

/* sv/btm_pkg.sv */
// Package with constants and types of the battery and thermistor monitor.
package btm_pkg;
  localparam int unsigned Window = 8;
  localparam int unsigned TableSize = 166;
  localparam logic [1:0] ModeSample = 2'd0;
  localparam logic [1:0] ModeTable = 2'd1;
  localparam logic [1:0] ModeClear = 2'd2;
  localparam logic [1:0] ModeSpare = 2'd3;
  localparam logic [1:0] PanelSmall = 2'd1;
  localparam logic [1:0] PanelLarge = 2'd2;
  localparam logic [2:0] RegPanel = 3'd0;
  localparam logic [2:0] RegLowSmall = 3'd1;
  localparam logic [2:0] RegLowLarge = 3'd2;
  localparam logic [2:0] RegOk = 3'd3;
  localparam logic [2:0] RegLimit = 3'd4;
  localparam logic [2:0] RegHigh = 3'd5;
  localparam logic [2:0] RegTempOk = 3'd6;
  localparam logic [1:0] EvNone = 2'd0;
  localparam logic [1:0] EvHigh = 2'd1;
  localparam logic [1:0] EvOk = 2'd2;
endpackage

/* sv/btm_ram.sv */
// Generic simple dual-port RAM (one write port, one read port) with registered read.
module btm_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 166
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

/* sv/btm_cell.sv */
// One window cell: holds a pair of samples and shifts them to its neighbor.
module btm_cell (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        shift_i,
  input  logic [11:0] bat_i,
  input  logic [11:0] thm_i,
  output logic [11:0] bat_o,
  output logic [11:0] thm_o
);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bat_o <= '0;
      thm_o <= '0;
    end else if (shift_i) begin
      bat_o <= bat_i;
      thm_o <= thm_i;
    end
  end
endmodule

/* sv/battery_thermistor_monitor.sv */
// Battery and thermistor monitor top level.
// The result is registered in StOut: table, clear and spare transactions go there straight
// from StIdle, a sample while the window fills passes StDone first, and an averaging one passes
// StSum, StWait, StLook and StDone. StOut waits for an earlier result to leave the output
// register, and the next transaction is accepted once the state is back in StIdle.
// Reset clears windows, counters and flags and sets registers to defaults; the table is undefined until written.
module battery_thermistor_monitor #(
  parameter int unsigned WINDOW = btm_pkg::Window,
  parameter int unsigned TABLE_SIZE = btm_pkg::TableSize
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // mode.
  input  logic [1:0]  s_axis_tuser,
  // battery_raw, thermistor_raw, past_startup, events_blocked,
  // table_index, table_value (low bit up).
  input  logic [55:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // battery_average, low_battery, temperature, min_temperature,
  // max_temperature, extreme_changed, temp_event, averaging_active.
  output logic [47:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);
  localparam int unsigned TW = $clog2(TABLE_SIZE);
  localparam int unsigned WW = $clog2(WINDOW);
  localparam int unsigned CW = $clog2(WINDOW + 1);
  localparam int unsigned SW = 12 + $clog2(WINDOW + 1);
  localparam int unsigned DK = SW + WW;
  localparam longint unsigned DM = ((64'd1 << DK) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam logic [SW:0] RecipM = DM[SW:0];

  typedef enum logic [2:0] {StIdle, StSum, StLook, StWait, StDone, StOut} state_e;
  state_e state_q;

  logic [1:0] panel_q;
  logic [11:0] low_s_q, low_l_q, ok_q;
  logic [15:0] limit_q;
  logic signed [7:0] high_q, tok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      panel_q <= '0; low_s_q <= '0; low_l_q <= '0; ok_q <= '0; limit_q <= '0;
      high_q <= 8'sd125; tok_q <= -8'sd40;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        btm_pkg::RegPanel:    panel_q <= cfg_data_i[1:0];
        btm_pkg::RegLowSmall: low_s_q <= cfg_data_i[11:0];
        btm_pkg::RegLowLarge: low_l_q <= cfg_data_i[11:0];
        btm_pkg::RegOk:       ok_q <= cfg_data_i[11:0];
        btm_pkg::RegLimit:    limit_q <= cfg_data_i;
        btm_pkg::RegHigh:     high_q <= cfg_data_i[7:0];
        btm_pkg::RegTempOk:   tok_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  logic [1:0] mode;
  logic [11:0] braw, traw;
  logic startup, blocked;
  logic [7:0] tidx;
  logic [15:0] tval;
  assign mode = s_axis_tuser;
  assign braw = s_axis_tdata[11:0];
  assign traw = s_axis_tdata[23:12];
  assign startup = s_axis_tdata[24];
  assign blocked = s_axis_tdata[25];
  assign tidx = s_axis_tdata[33:26];
  assign tval = s_axis_tdata[49:34];

  logic accept;
  assign s_axis_tready = (state_q == StIdle);
  assign accept = s_axis_tvalid && s_axis_tready;
  logic shift;
  assign shift = accept && mode == btm_pkg::ModeSample;
  logic [23:0] bprod;
  assign bprod = {12'd0, braw} * 24'd3000;

  // Cell chain: new sample enters the top cell; during summing the chain rotates.
  logic [11:0] cb [WINDOW+1];
  logic [11:0] ct [WINDOW+1];
  logic rot;
  assign rot = (state_q == StSum);
  assign cb[WINDOW] = rot ? cb[0] : bprod[23:12];
  assign ct[WINDOW] = rot ? ct[0] : traw;
  for (genvar g = 0; g < WINDOW; g++) begin : g_cell
    btm_cell u_cell (.clk_i, .rst_ni, .shift_i(shift || rot),
      .bat_i(cb[g+1]), .thm_i(ct[g+1]), .bat_o(cb[g]), .thm_o(ct[g]));
  end

  logic [CW-1:0] cnt_q;
  logic [WW:0] step_q;
  logic [SW-1:0] bsum_q, tsum_q;
  logic [11:0] tavg_q, bavg_q;
  logic startup_q, blocked_q;
  logic [15:0] fcnt_q;
  logic low_q, ext_q, hflag_q;
  logic signed [7:0] cur_q, max_q;
  logic signed [14:0] min_q;
  logic [1:0] ev_q;
  logic [TW-1:0] ti_q;
  logic [TW-1:0] raddr;
  logic [15:0] rdata;
  logic found_q;
  logic signed [7:0] lres_q;
  logic outv_q;
  logic [47:0] out_q;

  // Averages by multiplication with a rounded-up reciprocal, exact for every window sum.
  logic [2*SW:0] bq, tq;
  assign bq = {{(SW+1){1'b0}}, bsum_q} * {{SW{1'b0}}, RecipM};
  assign tq = {{(SW+1){1'b0}}, tsum_q} * {{SW{1'b0}}, RecipM};

  assign raddr = (state_q == StLook && {{(32-TW){1'b0}}, ti_q} != TABLE_SIZE - 1) ?
      ti_q + 1'b1 : ti_q;

  btm_ram #(.Width(16), .Depth(TABLE_SIZE)) u_ram (.clk_i,
    .we_i(accept && mode == btm_pkg::ModeTable && {24'd0, tidx} < TABLE_SIZE),
    .waddr_i(tidx[TW-1:0]), .wdata_i(tval), .raddr_i(raddr), .rdata_o(rdata));

  logic [11:0] thr;
  logic [8:0] ti9;
  logic signed [8:0] cand;
  assign thr = (panel_q == btm_pkg::PanelSmall) ? low_s_q : low_l_q;
  assign ti9 = 9'(ti_q);
  assign cand = (ti9 == 9'd0) ? -9'sd40 :
      (($signed(ti9) - 9'sd41 > 9'sd125) ? 9'sd125 : $signed(ti9) - 9'sd41);

  logic signed [7:0] t;
  assign t = found_q ? lres_q : 8'sd125;

  logic avg_now;
  logic signed [7:0] tnew;
  logic min_upd, max_upd;
  assign avg_now = ({{(32-CW){1'b0}}, cnt_q} >= WINDOW) && ti_q != '0;
  assign tnew = avg_now ? t : cur_q;
  assign min_upd = $signed({{7{t[7]}}, t}) < min_q;
  assign max_upd = t > max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; cnt_q <= '0; step_q <= '0; bsum_q <= '0; tsum_q <= '0;
      tavg_q <= '0; bavg_q <= '0; startup_q <= 1'b0; blocked_q <= 1'b0;
      fcnt_q <= '0; low_q <= 1'b0; ext_q <= 1'b0; hflag_q <= 1'b0;
      cur_q <= '0; max_q <= '0; min_q <= 15'sd10000; ev_q <= btm_pkg::EvNone;
      ti_q <= '0; found_q <= 1'b0; lres_q <= '0; outv_q <= 1'b0; out_q <= '0;
    end else begin
      if (outv_q && m_axis_tready && state_q != StOut) outv_q <= 1'b0;
      case (state_q)
        StIdle: if (accept) begin
          ev_q <= btm_pkg::EvNone;
          startup_q <= startup; blocked_q <= blocked;
          if (mode == btm_pkg::ModeClear) ext_q <= 1'b0;
          if (mode == btm_pkg::ModeSample && {{(32-CW){1'b0}}, cnt_q} >= WINDOW) begin
            state_q <= StSum; step_q <= '0; bsum_q <= '0; tsum_q <= '0;
          end else begin
            if (mode == btm_pkg::ModeSample) cnt_q <= cnt_q + 1'b1;
            state_q <= (mode == btm_pkg::ModeSample) ? StDone : StOut;
          end
        end
        StSum: begin
          bsum_q <= bsum_q + {{(SW-12){1'b0}}, cb[0]};
          tsum_q <= tsum_q + {{(SW-12){1'b0}}, ct[0]};
          step_q <= step_q + 1'b1;
          if ({{(31-WW){1'b0}}, step_q} == WINDOW - 1) begin
            state_q <= StWait; ti_q <= '0; found_q <= 1'b0;
          end
        end
        StWait: begin
          if (step_q != '0) begin
            bavg_q <= bq[DK +: 12];
            tavg_q <= tq[DK +: 12];
            step_q <= '0;
          end else state_q <= StLook;
        end
        StLook: begin
          if (!found_q && {4'd0, tavg_q} > rdata) begin
            found_q <= 1'b1; lres_q <= cand[7:0];
          end
          if ({{(32-TW){1'b0}}, ti_q} == TABLE_SIZE - 1) state_q <= StDone;
          else ti_q <= ti_q + 1'b1;
        end
        StDone: begin
          state_q <= StOut;
          if (avg_now) begin
            cur_q <= t;
            if (startup_q) begin
              if (min_upd) min_q <= {{7{t[7]}}, t};
              if (max_upd) max_q <= t;
              if (min_upd || max_upd) ext_q <= 1'b1;
            end
            if (panel_q == btm_pkg::PanelSmall || panel_q == btm_pkg::PanelLarge) begin
              if (!low_q && bavg_q < thr) begin
                if (fcnt_q < limit_q) fcnt_q <= fcnt_q + 1'b1; else low_q <= 1'b1;
              end else if (bavg_q > ok_q && low_q) begin
                if (fcnt_q != '0) fcnt_q <= fcnt_q - 1'b1; else low_q <= 1'b0;
              end else if (!low_q && bavg_q > thr) begin
                if (fcnt_q != '0) fcnt_q <= fcnt_q - 1'b1;
              end
            end
          end
          if (!blocked_q) begin
            if (tnew > high_q && !hflag_q) begin
              hflag_q <= 1'b1; ev_q <= btm_pkg::EvHigh;
            end else if (hflag_q && tnew < tok_q) begin
              hflag_q <= 1'b0; ev_q <= btm_pkg::EvOk;
            end
          end
          ti_q <= '0;
        end
        StOut: begin
          if (!outv_q || m_axis_tready) begin
            out_q <= {{{(32-CW){1'b0}}, cnt_q} >= WINDOW, ev_q, ext_q,
                      max_q, min_q, cur_q, low_q, bavg_q};
            outv_q <= 1'b1; state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign m_axis_tvalid = outv_q;
  assign m_axis_tdata = out_q;
endmodule

/* sv/btm_checker.sv */
// Port-level checker for the monitor, bound to the top level.
`include "assert_macros.svh"
module btm_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [47:0] m_axis_tdata
);
  `ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `ASSERT_IMP(a_ev_code, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[46:45] != 2'd3)
  `ASSERT_NXT(a_busy, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)
endmodule
bind battery_thermistor_monitor btm_checker u_btm_checker (.*);

/* bench/battery_thermistor_monitor_checker.sv */
// Checker that predicts and compares every report of the battery and thermistor monitor.
module battery_thermistor_monitor_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [1:0]  s_axis_tuser,
  input  logic [55:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [47:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);
  typedef struct packed {
    logic        averaging;
    logic [1:0]  event_code;
    logic        extreme;
    logic [7:0]  max_temp;
    logic [14:0] min_temp;
    logic [7:0]  temp;
    logic        low_batt;
    logic [11:0] batt_avg;
  } report_t;

  report_t expected_reports[$];

  logic [1:0]  panel;
  int          low_small, low_large, ok_level, limit;
  int          high_temp, ok_temp;
  int          batt_win[btm_pkg::Window];
  int          therm_win[btm_pkg::Window];
  int          lookup_table[btm_pkg::TableSize];
  int          samples, filter_cnt, cur_temp, min_temp, max_temp, batt_avg;
  bit          low_flag, extreme_flag, hot_flag;

  assign pending_o = expected_reports.size();

  function automatic int temp_from_level(int level);
    for (int i = 0; i < btm_pkg::TableSize; i++) begin
      if (level > lookup_table[i]) begin
        if (i == 0) return -40;
        return (i - 41 > 125) ? 125 : i - 41;
      end
    end
    return 125;
  endfunction

  task automatic run_battery_filter(int level);
    int thr;
    if (panel == btm_pkg::PanelSmall) thr = low_small;
    else if (panel == btm_pkg::PanelLarge) thr = low_large;
    else return;
    if (!low_flag && level < thr) begin
      if (filter_cnt < limit) filter_cnt++;
      else low_flag = 1'b1;
    end else if (level > ok_level && low_flag) begin
      if (filter_cnt > 0) filter_cnt--;
      else low_flag = 1'b0;
    end else if (!low_flag && level > thr) begin
      if (filter_cnt > 0) filter_cnt--;
    end
  endtask

  task automatic predict_report(logic [1:0] mode, logic [55:0] d);
    logic [1:0] ev;
    int bsum, tsum;
    report_t r;
    ev = btm_pkg::EvNone;
    bsum = 0;
    tsum = 0;
    if (mode == btm_pkg::ModeSample) begin
      for (int i = 1; i < btm_pkg::Window; i++) begin
        batt_win[i-1] = batt_win[i];
        therm_win[i-1] = therm_win[i];
      end
      batt_win[btm_pkg::Window-1] = (int'(d[11:0]) * 3000) >> 12;
      therm_win[btm_pkg::Window-1] = int'(d[23:12]);
      if (samples >= btm_pkg::Window) begin
        for (int i = 0; i < btm_pkg::Window; i++) begin
          bsum += batt_win[i];
          tsum += therm_win[i];
        end
        batt_avg = bsum / btm_pkg::Window;
        run_battery_filter(batt_avg);
        cur_temp = temp_from_level(tsum / btm_pkg::Window);
        if (d[24]) begin
          if (cur_temp < min_temp) begin
            min_temp = cur_temp;
            extreme_flag = 1'b1;
          end
          if (cur_temp > max_temp) begin
            max_temp = cur_temp;
            extreme_flag = 1'b1;
          end
        end
      end else begin
        samples++;
      end
      if (!d[25]) begin
        if (cur_temp > high_temp && !hot_flag) begin
          hot_flag = 1'b1;
          ev = btm_pkg::EvHigh;
        end else if (hot_flag && cur_temp < ok_temp) begin
          hot_flag = 1'b0;
          ev = btm_pkg::EvOk;
        end
      end
    end else if (mode == btm_pkg::ModeTable) begin
      if (int'(d[33:26]) < btm_pkg::TableSize) lookup_table[d[33:26]] = int'(d[49:34]);
    end else if (mode == btm_pkg::ModeClear) begin
      extreme_flag = 1'b0;
    end
    r.batt_avg = batt_avg[11:0];
    r.low_batt = low_flag;
    r.temp = cur_temp[7:0];
    r.min_temp = min_temp[14:0];
    r.max_temp = max_temp[7:0];
    r.extreme = extreme_flag;
    r.event_code = ev;
    r.averaging = samples >= btm_pkg::Window;
    expected_reports.push_back(r);
  endtask

  task automatic flag_mismatch(string field, int exp_val, int got_val);
    if (fail_count_o < 10)
      $display("mismatch in %s: expected %0d, got %0d", field, exp_val, got_val);
    fail_count_o++;
  endtask

  task automatic compare_report(report_t got);
    report_t e;
    if (expected_reports.size() == 0) begin
      if (fail_count_o < 10) $display("report %h arrived with none expected", got);
      fail_count_o++;
      return;
    end
    e = expected_reports.pop_front();
    if (got.batt_avg !== e.batt_avg) flag_mismatch("battery_average", e.batt_avg, got.batt_avg);
    if (got.low_batt !== e.low_batt) flag_mismatch("low_battery", e.low_batt, got.low_batt);
    if (got.temp !== e.temp)
      flag_mismatch("temperature", $signed(e.temp), $signed(got.temp));
    if (got.min_temp !== e.min_temp)
      flag_mismatch("min_temperature", $signed(e.min_temp), $signed(got.min_temp));
    if (got.max_temp !== e.max_temp)
      flag_mismatch("max_temperature", $signed(e.max_temp), $signed(got.max_temp));
    if (got.extreme !== e.extreme) flag_mismatch("extreme_changed", e.extreme, got.extreme);
    if (got.event_code !== e.event_code)
      flag_mismatch("temp_event", e.event_code, got.event_code);
    if (got.averaging !== e.averaging)
      flag_mismatch("averaging_active", e.averaging, got.averaging);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      panel = '0;
      low_small = 0;
      low_large = 0;
      ok_level = 0;
      limit = 0;
      high_temp = 125;
      ok_temp = -40;
      samples = 0;
      filter_cnt = 0;
      cur_temp = 0;
      min_temp = 10000;
      max_temp = 0;
      batt_avg = 0;
      low_flag = 1'b0;
      extreme_flag = 1'b0;
      hot_flag = 1'b0;
      fail_count_o = 0;
      for (int i = 0; i < btm_pkg::Window; i++) begin
        batt_win[i] = 0;
        therm_win[i] = 0;
      end
      for (int i = 0; i < btm_pkg::TableSize; i++) lookup_table[i] = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          btm_pkg::RegPanel:    panel = cfg_data_i[1:0];
          btm_pkg::RegLowSmall: low_small = int'(cfg_data_i[11:0]);
          btm_pkg::RegLowLarge: low_large = int'(cfg_data_i[11:0]);
          btm_pkg::RegOk:       ok_level = int'(cfg_data_i[11:0]);
          btm_pkg::RegLimit:    limit = int'(cfg_data_i);
          btm_pkg::RegHigh:     high_temp = int'($signed(cfg_data_i[7:0]));
          btm_pkg::RegTempOk:   ok_temp = int'($signed(cfg_data_i[7:0]));
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) predict_report(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) compare_report(report_t'(m_axis_tdata));
    end
  end
endmodule

/* bench/battery_thermistor_monitor_test.sv */
// Top of the monitor testbench: clock, reset, stimulus, receiver stalls and verdict.
module battery_thermistor_monitor_test;
  localparam int CycleLimit = 3000000;
  localparam int RandomItems = 1764;
  localparam int Phases = 6;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [1:0]  s_axis_tuser = '0;
  logic [55:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;
  int          fail_count, pending;
  int          cycles = 0;
  int          stall_style = 0;
  int          batt_level, therm_level;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  battery_thermistor_monitor i_dut (.*);

  battery_thermistor_monitor_checker i_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tuser, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // The receiver switches between always ready, random stalls and long stalls.
  always @(posedge clk_i) begin
    if (cycles % 512 == 0) stall_style <= $urandom_range(0, 3);
    case (stall_style)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      2: m_axis_tready <= ($urandom_range(0, 7) == 0);
      default: m_axis_tready <= ((cycles / 40) % 2 == 0);
    endcase
  end

  function automatic logic [55:0] pack_item(logic [11:0] braw, logic [11:0] traw,
      logic startup, logic blocked, logic [7:0] idx, logic [15:0] val);
    return {6'b0, val, idx, blocked, startup, traw, braw};
  endfunction

  task automatic send_item(logic [1:0] mode, logic [55:0] d);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= mode;
    s_axis_tdata <= d;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_sample(logic [11:0] braw, logic [11:0] traw, logic startup,
      logic blocked);
    send_item(btm_pkg::ModeSample,
              pack_item(braw, traw, startup, blocked, 8'($urandom), 16'($urandom)));
  endtask

  task automatic send_other(logic [1:0] mode);
    send_item(mode, pack_item(12'($urandom), 12'($urandom), 1'($urandom), 1'($urandom),
                              8'($urandom), 16'($urandom)));
  endtask

  task automatic write_regs(int pnl, int lsm, int llg, int okl, int lim, int hi, int lo);
    logic [15:0] vals[7];
    vals = '{pnl[15:0], lsm[15:0], llg[15:0], okl[15:0], lim[15:0], {8'h0, hi[7:0]},
             {8'h0, lo[7:0]}};
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (10) @(posedge clk_i);
    for (int i = 0; i < 7; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= i[2:0];
      cfg_data_i <= vals[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [11:0] wander(ref int level, input int step, input int noise);
    int v;
    level += $urandom_range(0, 2 * step) - step;
    if (level < 0) level = 0;
    if (level > 4095) level = 4095;
    v = level + $urandom_range(0, 2 * noise) - noise;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[11:0];
  endfunction

  task automatic random_phase(int count);
    int kind, gap, burst;
    burst = 0;
    for (int n = 0; n < count; n++) begin
      if (burst == 0) begin
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
        if (gap > 0) begin
          s_axis_tvalid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        burst = $urandom_range(1, 20);
      end
      burst--;
      kind = $urandom_range(0, 99);
      if (kind < 86) begin
        if ($urandom_range(0, 30) == 0) batt_level = $urandom_range(0, 4095);
        if ($urandom_range(0, 30) == 0) therm_level = $urandom_range(0, 4095);
        send_sample(wander(batt_level, 120, 40), wander(therm_level, 150, 60),
                    $urandom_range(0, 3) != 0, $urandom_range(0, 4) == 0);
      end else if (kind < 92) begin
        send_item(btm_pkg::ModeTable,
                  pack_item(12'($urandom), 12'($urandom), 1'($urandom), 1'($urandom),
                            8'($urandom_range(0, 255)), 16'($urandom)));
      end else if (kind < 97) begin
        send_other(btm_pkg::ModeClear);
      end else begin
        send_other(btm_pkg::ModeSpare);
      end
    end
  endtask

  initial begin
    batt_level = 2048;
    therm_level = 2048;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_regs(1, 1500, 2000, 1800, 0, 125, -40);
    // A descending conversion table is loaded before any lookup can happen.
    for (int i = 0; i < btm_pkg::TableSize; i++)
      send_item(btm_pkg::ModeTable,
                pack_item(12'($urandom), 12'($urandom), 1'($urandom), 1'($urandom),
                          i[7:0], 16'(4000 - 24 * i)));
    send_item(btm_pkg::ModeTable, pack_item(12'd0, 12'd0, 1'b0, 1'b0, 8'd166, 16'hFFFF));
    send_item(btm_pkg::ModeTable, pack_item(12'd0, 12'd0, 1'b0, 1'b0, 8'd255, 16'h0000));
    for (int i = 0; i < 8; i++)
      send_sample(i[0] ? 12'hFFF : 12'h000, i[0] ? 12'h000 : 12'hFFF, 1'b1, 1'b0);
    send_sample(12'hFFF, 12'h000, 1'b1, 1'b0);
    send_sample(12'hFFF, 12'h000, 1'b1, 1'b1);
    send_item(btm_pkg::ModeClear, pack_item(12'd0, 12'd0, 1'b0, 1'b0, 8'd0, 16'd0));
    send_item(btm_pkg::ModeSpare, pack_item(12'hFFF, 12'hFFF, 1'b1, 1'b1, 8'hFF, 16'hFFFF));
    for (int i = 0; i < 8; i++) send_sample(12'h000, 12'hFFF, 1'b1, 1'b0);
    send_sample(12'h000, 12'hFFF, 1'b0, 1'b1);
    send_sample(12'h000, 12'hFFF, 1'b1, 1'b0);

    for (int p = 0; p < Phases; p++) begin
      case (p)
        0: write_regs(2, 3000, 3000, 3000, 65535, -40, 125);
        1: write_regs(2, 1200, 1600, 1700, 3, 20, 0);
        2: write_regs(3, 2500, 2500, 2600, 1, 60, 40);
        3: write_regs(0, 0, 0, 0, 0, 125, -40);
        default: write_regs($urandom_range(1, 2), $urandom_range(0, 3000),
                            $urandom_range(0, 3000), $urandom_range(0, 3000),
                            $urandom_range(0, 8), $urandom_range(0, 165) - 40,
                            $urandom_range(0, 165) - 40);
      endcase
      random_phase(RandomItems / Phases);
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
